// ----- sv/imufg_pkg.sv -----
`timescale 1ns / 1ps

package imufg_pkg;

  // Frame layout.
  localparam int FRAME_LEN = 11;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int TYPE_SLOT = 1;
  localparam int LAST_KEPT = 7;

  localparam logic [7:0] HDR_BYTE        = 8'h55;
  localparam logic [7:0] KIND_ACCEL_BYTE = 8'h51;
  localparam logic [7:0] KIND_ANGLE_BYTE = 8'h53;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int DATA_W = 16;
  localparam int LIN_W  = 17;
  localparam int GRAV_W = 15;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd2048;

  // Fixed-point gravity math.
  localparam int TRIG_FRAC = 14;
  localparam int OPND_W    = 17;
  localparam int PROD_W    = 2 * OPND_W;

  // Sine table: Q1.14, one quarter wave of sine and one of cosine.
  localparam int SINE_ENTRIES = 1024;
  localparam int IDX_W        = $clog2(SINE_ENTRIES);
  localparam int QTR          = SINE_ENTRIES / 4;
  localparam int QTR_W        = IDX_W - 2;
  localparam int MAG_W        = 15;

  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam int          SERIES_TERMS = 8;

  // Command queue.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [MAG_W-1:0] qtab_t [QTR];

  typedef enum logic {
    KIND_ACCEL = 1'b0,
    KIND_ANGLE = 1'b1
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t              kind;
    logic signed [DATA_W-1:0] v0;
    logic signed [DATA_W-1:0] v1;
    logic signed [DATA_W-1:0] v2;
  } frame_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_MUL_D,
    ST_MUL_E,
    ST_MUL_F,
    ST_LIN,
    ST_EMIT
  } back_state_t;

  // Builds one quarter wave with an integer Taylor series in Q30, rounded to Q14.
  // Evaluated only at elaboration.
  function automatic qtab_t build_qtab(input logic want_cos);
    qtab_t              tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        Denom;
    logic [63:0]        v;
    logic signed [63:0] sum;
    int                 j;
    int                 k;
    for (j = 0; j < QTR; j++) begin
      x    = (HALF_PI_Q30 * 64'(4 * j)) / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      term = want_cos ? ONE_Q30 : x;
      sum  = $signed(term);
      for (k = 1; k <= SERIES_TERMS; k++) begin
        Denom = want_cos ? 64'((2 * k - 1) * (2 * k)) : 64'((2 * k) * (2 * k + 1));
        term  = ((term * x2) >> 30) / Denom;
        if (k[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      v = (sum < 0) ? 64'd0 : $unsigned(sum);
      tab[j] = MAG_W'((v + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab(1'b0);
  localparam qtab_t COS_QTAB = build_qtab(1'b1);

  // Full-wave lookup: quadrant bit 0 picks the cosine quarter, bit 1 negates.
  function automatic logic signed [DATA_W-1:0] trig_value(input logic [IDX_W-1:0] idx);
    logic [1:0]               quad;
    logic [QTR_W-1:0]         j;
    logic [MAG_W-1:0]         mag;
    logic signed [DATA_W-1:0] smag;
    quad = idx[IDX_W-1 -: 2];
    j    = idx[QTR_W-1:0];
    mag  = quad[0] ? COS_QTAB[j] : SIN_QTAB[j];
    smag = $signed({1'b0, mag});
    return quad[1] ? -smag : smag;
  endfunction

endpackage

// ----- sv/imufg_ifs.sv -----
`timescale 1ns / 1ps

interface imufg_in_if;
  import imufg_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface imufg_cfg_if;
  import imufg_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRAV_W-1:0] gravity_lsb;
  modport source(output valid, output gravity_lsb, input ready);
  modport sink(input valid, input gravity_lsb, output ready);
endinterface

interface imufg_out_if;
  import imufg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     frame_kind;
  logic signed [DATA_W-1:0] accel_x;
  logic signed [DATA_W-1:0] accel_y;
  logic signed [DATA_W-1:0] accel_z;
  logic signed [DATA_W-1:0] roll_angle;
  logic signed [DATA_W-1:0] pitch_angle;
  logic signed [DATA_W-1:0] yaw_raw;
  logic signed [LIN_W-1:0]  lin_x;
  logic signed [LIN_W-1:0]  lin_y;
  logic signed [LIN_W-1:0]  lin_z;
  modport source(output valid, output frame_kind, output accel_x, output accel_y,
                 output accel_z, output roll_angle, output pitch_angle, output yaw_raw,
                 output lin_x, output lin_y, output lin_z, input ready);
  modport sink(input valid, input frame_kind, input accel_x, input accel_y,
               input accel_z, input roll_angle, input pitch_angle, input yaw_raw,
               input lin_x, input lin_y, input lin_z, output ready);
endinterface

// ----- sv/imufg_front.sv -----
`timescale 1ns / 1ps

module imufg_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [imufg_pkg::BYTE_W-1:0] in_byte,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output imufg_pkg::frame_cmd_t        cmd
);
  import imufg_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] csum;
  logic [BYTE_W-1:0] frame_bytes [TYPE_SLOT:LAST_KEPT];
  logic              last;
  logic              accept;
  logic              good;

  assign last     = (pos == POS_W'(FRAME_LEN - 1));
  // Only the checksum byte may need room in the queue.
  assign in_ready = !last || cmd_ready;
  assign accept   = in_valid && in_ready;

  assign good = last && (csum == in_byte) &&
                ((frame_bytes[TYPE_SLOT] == KIND_ACCEL_BYTE) ||
                 (frame_bytes[TYPE_SLOT] == KIND_ANGLE_BYTE));
  assign cmd_valid = in_valid && good;

  assign cmd.kind = (frame_bytes[TYPE_SLOT] == KIND_ANGLE_BYTE) ? KIND_ANGLE : KIND_ACCEL;
  assign cmd.v0   = $signed({frame_bytes[3], frame_bytes[2]});
  assign cmd.v1   = $signed({frame_bytes[5], frame_bytes[4]});
  assign cmd.v2   = $signed({frame_bytes[7], frame_bytes[6]});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      if (pos == '0) begin
        if (in_byte == HDR_BYTE) begin
          pos <= POS_W'(1);
        end
      end else if (last) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == '0) begin
        csum <= in_byte;
      end else begin
        csum <= csum + in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = TYPE_SLOT; i <= LAST_KEPT; i++) begin
      if (accept && (pos == POS_W'(i))) begin
        frame_bytes[i] <= in_byte;
      end
    end
  end

endmodule

// ----- sv/imufg_cmd_fifo.sv -----
`timescale 1ns / 1ps

module imufg_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  imufg_pkg::frame_cmd_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output imufg_pkg::frame_cmd_t rd_data
);
  import imufg_pkg::*;

  frame_cmd_t           slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;
  logic                 push;
  logic                 pop;

  assign wr_ready = (count != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (FIFO_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- sv/imufg_back.sv -----
`timescale 1ns / 1ps

module imufg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  imufg_pkg::frame_cmd_t cmd,
  imufg_cfg_if.sink            cfg,
  imufg_out_if.source          result
);
  import imufg_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [GRAV_W-1:0]        gravity;
  logic signed [DATA_W-1:0] held_accel  [3];
  logic signed [DATA_W-1:0] held_angle  [3];
  logic signed [LIN_W-1:0]  held_linear [3];
  frame_kind_t              cur_kind;

  logic signed [DATA_W-1:0] sin_p, cos_p, sin_r, cos_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] gx, gy, gz;

  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [OPND_W-1:0] prod_hi;
  logic signed [OPND_W-1:0] grav_op;
  logic [IDX_W-1:0]         idx_p, idx_r;
  logic                     emit_fire;

  logic                     out_valid;
  frame_kind_t              out_kind;
  logic signed [DATA_W-1:0] out_accel [3];
  logic signed [DATA_W-1:0] out_angle [3];
  logic signed [LIN_W-1:0]  out_lin   [3];

  assign cfg.ready = 1'b1;

  // Product shifted down by the Q14 scale; the kept slice holds every value it can take.
  assign prod_hi = prod[OPND_W + TRIG_FRAC - 1:TRIG_FRAC];
  assign grav_op = $signed({{(OPND_W - GRAV_W){1'b0}}, gravity});
  assign mul_res = mul_a * mul_b;
  assign idx_r   = held_angle[0][DATA_W-1 -: IDX_W];
  assign idx_p   = held_angle[1][DATA_W-1 -: IDX_W];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.kind == KIND_ANGLE) ? ST_TRIG : ST_EMIT;
        end
      end
      ST_TRIG:  state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_MUL_C;
      ST_MUL_C: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_MUL_E;
      ST_MUL_E: state_next = ST_MUL_F;
      ST_MUL_F: state_next = ST_LIN;
      ST_LIN:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    emit_fire = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_IDLE: cmd_ready = 1'b1;
      ST_MUL_A: begin
        mul_a = OPND_W'(sin_p);
        mul_b = grav_op;
      end
      ST_MUL_B: begin
        mul_a = OPND_W'(cos_p);
        mul_b = OPND_W'(sin_r);
      end
      ST_MUL_C: begin
        mul_a = prod_hi;
        mul_b = grav_op;
      end
      ST_MUL_D: begin
        mul_a = OPND_W'(cos_p);
        mul_b = OPND_W'(cos_r);
      end
      ST_MUL_E: begin
        mul_a = prod_hi;
        mul_b = grav_op;
      end
      ST_EMIT: emit_fire = !out_valid || result.ready;
      default: cmd_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gravity   <= GRAV_RESET;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        held_accel[k]  <= '0;
        held_angle[k]  <= '0;
        held_linear[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        gravity <= cfg.gravity_lsb;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_valid && cmd_ready) begin
        if (cmd.kind == KIND_ANGLE) begin
          held_angle[0] <= cmd.v0;
          held_angle[1] <= cmd.v1;
          held_angle[2] <= cmd.v2;
        end else begin
          held_accel[0] <= cmd.v0;
          held_accel[1] <= cmd.v1;
          held_accel[2] <= cmd.v2;
        end
      end
      if (state == ST_LIN) begin
        held_linear[0] <= {held_accel[0][DATA_W-1], held_accel[0]} - gx;
        held_linear[1] <= {held_accel[1][DATA_W-1], held_accel[1]} - gy;
        held_linear[2] <= {held_accel[2][DATA_W-1], held_accel[2]} - gz;
      end
    end
  end

  // Datapath registers of the gravity sequence and the result register.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cur_kind <= cmd.kind;
    end
    if (state == ST_TRIG) begin
      sin_p <= trig_value(idx_p);
      cos_p <= trig_value(idx_p + IDX_W'(QTR));
      sin_r <= trig_value(idx_r);
      cos_r <= trig_value(idx_r + IDX_W'(QTR));
    end
    if ((state == ST_MUL_A) || (state == ST_MUL_B) || (state == ST_MUL_C) ||
        (state == ST_MUL_D) || (state == ST_MUL_E)) begin
      prod <= mul_res;
    end
    if (state == ST_MUL_B) begin
      gx <= -prod_hi;
    end
    if (state == ST_MUL_D) begin
      gy <= prod_hi;
    end
    if (state == ST_MUL_F) begin
      gz <= prod_hi;
    end
    if (emit_fire) begin
      out_kind <= cur_kind;
      for (int k = 0; k < 3; k++) begin
        out_accel[k] <= held_accel[k];
        out_angle[k] <= held_angle[k];
        out_lin[k]   <= held_linear[k];
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.frame_kind  = out_kind;
  assign result.accel_x     = out_accel[0];
  assign result.accel_y     = out_accel[1];
  assign result.accel_z     = out_accel[2];
  assign result.roll_angle  = out_angle[0];
  assign result.pitch_angle = out_angle[1];
  assign result.yaw_raw     = out_angle[2];
  assign result.lin_x       = out_lin[0];
  assign result.lin_y       = out_lin[1];
  assign result.lin_z       = out_lin[2];

endmodule

// ----- sv/imu_frame_parser_gravity_removal_top.sv -----
`timescale 1ns / 1ps

// Port     Role    Payload                                   Beat means
// rx       sink    rx_byte[7:0]                              one received serial byte
// cfg      sink    gravity_lsb[14:0]                         one g in raw accel units
// result   source  frame_kind, accel/angle xyz, lin xyz      one good frame, all held values
//
// Flow: rx takes one byte per cycle unless a checksum byte waits on a full queue. A good
// acceleration frame goes to result without the products; an angle frame first passes the shared
// 17x17 multiplier that runs the five gravity products one after another.
// Reset: synchronous; clears frame position, held values and queue, loads gravity_lsb 2048.
// Stalls: a two-frame queue sits between parser and math; only a checksum byte waits when
// it is full. result holds its beat until taken.

module imu_frame_parser_gravity_removal_top (
  input  logic         clk,
  input  logic         rst,
  imufg_in_if.sink     rx,
  imufg_cfg_if.sink    cfg,
  imufg_out_if.source  result
);
  import imufg_pkg::*;

  // Parser to queue.
  logic       front_valid;
  logic       front_ready;
  frame_cmd_t front_cmd;

  // Queue to gravity engine.
  logic       back_valid;
  logic       back_ready;
  frame_cmd_t back_cmd;

  // The parser hunts for the header, sums the checksum and classifies the frame type.
  // Only good frames of the two known types are pushed; everything else is dropped here.
  imufg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .in_byte   (rx.rx_byte),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  // Two frames of slack, so the parser keeps taking bytes while the math runs.
  imufg_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  // The back end keeps the held values, runs the sine lookups and the gravity products,
  // and owns the result register.
  imufg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .cfg       (cfg),
    .result    (result)
  );

endmodule
